### rtl/plru_pkg.sv
// ----------------------------------------------------------------------------
// plru_pkg
// Shared constants, codes and types of the pinned LRU tile cache policy.
// ----------------------------------------------------------------------------
package plru_pkg;

  localparam int ENTRIES = 16;
  localparam int IW      = $clog2(ENTRIES);
  localparam int CW      = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_FLUSH   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_ABSENT = 2'd1;
  localparam logic [1:0] STAT_PINNED = 2'd2;

  localparam logic KIND_WB     = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_CHECK,
    S_VSCAN,
    S_EVICT,
    S_INSTALL,
    S_FLUSH,
    S_FLUSH_END,
    S_CLEAR,
    S_WAIT
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic        hit;
    logic [3:0]  slot;
    logic [15:0] row;
    logic [15:0] col;
    logic [3:0]  red;
    logic        last;
  } res_t;

endpackage

### rtl/pinned_lru_tile_cache_policy_top.sv
// ----------------------------------------------------------------------------
// pinned_lru_tile_cache_policy_top
// One operation at a time; the entry scan moves on by one entry per cycle
// while no result waits on the output.
// Reset (rst_n low, synchronous): table empty, counters zero, budget 1048576.
// ----------------------------------------------------------------------------
module pinned_lru_tile_cache_policy_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_tile_row,
  input  logic [15:0] in_tile_col,
  input  logic [20:0] in_tile_size,
  input  logic        in_backing_valid,
  input  logic [3:0]  in_reduction_kind,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [1:0]  out_status,
  output logic        out_hit,
  output logic [3:0]  out_slot,
  output logic [15:0] out_row,
  output logic [15:0] out_col,
  output logic [3:0]  out_reduction,
  output logic [4:0]  out_resident_tiles,
  output logic [31:0] out_hit_total,
  output logic [31:0] out_miss_total,
  output logic        out_last
);
  import plru_pkg::*;

  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [23:0] cap_r;
  logic [ENTRIES-1:0] valid_r, valid_nxt, dirty_r, dirty_nxt, pin_r, pin_nxt;
  logic [IW-1:0] age_r [ENTRIES], age_nxt [ENTRIES];
  logic [15:0] erow_r [ENTRIES];
  logic [15:0] ecol_r [ENTRIES];
  logic [20:0] esize_r [ENTRIES];
  logic [3:0]  ered_r [ENTRIES];
  logic        wr_en;
  logic [IW-1:0] wr_slot;
  logic [24:0] words_r, words_nxt;
  logic [31:0] hits_r, hits_nxt, miss_r, miss_nxt;
  logic [CW-1:0] nval_r, nval_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  op_t         op_r, op_nxt;
  logic [15:0] row_r, row_nxt, col_r, col_nxt;
  logic [20:0] size_r, size_nxt;
  logic        bv_r, bv_nxt;
  logic [3:0]  red_r, red_nxt;
  logic        vf_r, vf_nxt, vd_r, vd_nxt;
  logic [IW-1:0] vs_r, vs_nxt, va_r, va_nxt;
  logic [15:0] vrow_r, vrow_nxt, vcol_r, vcol_nxt;
  logic [20:0] vsize_r, vsize_nxt;
  logic [3:0]  vred_r, vred_nxt;
  logic        ov_r, ov_nxt;
  res_t        res_r, res_nxt;
  logic        take;
  logic [IW-1:0] free_slot;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_kind = res_r.kind;
  assign out_status = res_r.status;
  assign out_hit = res_r.hit;
  assign out_slot = res_r.slot;
  assign out_row = res_r.row;
  assign out_col = res_r.col;
  assign out_reduction = res_r.red;
  assign out_last = res_r.last;
  assign out_resident_tiles = 5'(nval_r);
  assign out_hit_total = hits_r;
  assign out_miss_total = miss_r;

  always_comb begin
    free_slot = '0;
    for (int j = ENTRIES - 1; j >= 0; j--) begin
      if (!valid_r[j]) free_slot = IW'(j);
    end
  end

  assign take = valid_r[idx_r] && !pin_r[idx_r] && (!vf_r || age_r[idx_r] > va_r);

  always_comb begin
    state_nxt = state_r; ret_nxt = ret_r;
    valid_nxt = valid_r; dirty_nxt = dirty_r; pin_nxt = pin_r;
    for (int j = 0; j < ENTRIES; j++) age_nxt[j] = age_r[j];
    wr_en = 1'b0; wr_slot = free_slot;
    words_nxt = words_r; hits_nxt = hits_r; miss_nxt = miss_r; nval_nxt = nval_r;
    idx_nxt = idx_r; op_nxt = op_r; row_nxt = row_r; col_nxt = col_r;
    size_nxt = size_r; bv_nxt = bv_r; red_nxt = red_r;
    vf_nxt = vf_r; vd_nxt = vd_r; vs_nxt = vs_r; va_nxt = va_r;
    vrow_nxt = vrow_r; vcol_nxt = vcol_r; vsize_nxt = vsize_r; vred_nxt = vred_r;
    ov_nxt = ov_r; res_nxt = res_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = op_t'(in_operation);
          row_nxt = in_tile_row; col_nxt = in_tile_col; size_nxt = in_tile_size;
          bv_nxt = in_backing_valid; red_nxt = in_reduction_kind;
          idx_nxt = '0;
          case (op_t'(in_operation))
            OP_ACQUIRE, OP_RELEASE: state_nxt = S_LOOKUP;
            OP_FLUSH: state_nxt = S_FLUSH;
            default: state_nxt = S_CLEAR;
          endcase
        end
      end
      S_LOOKUP: begin
        if (valid_r[idx_r] && erow_r[idx_r] == row_r && ecol_r[idx_r] == col_r) begin
          ov_nxt = 1'b1; state_nxt = S_WAIT;
          res_nxt = '{KIND_STATUS, STAT_OK, 1'b0, 4'(idx_r), row_r, col_r,
                      ered_r[idx_r], 1'b1};
          if (op_r == OP_ACQUIRE) begin
            if (hits_r != '1) hits_nxt = hits_r + 32'd1;
            for (int j = 0; j < ENTRIES; j++) begin
              if (valid_r[j] && IW'(j) != idx_r && age_r[j] < age_r[idx_r])
                age_nxt[j] = age_r[j] + 1'b1;
            end
            age_nxt[idx_r] = '0;
            pin_nxt[idx_r] = 1'b1;
            res_nxt.hit = 1'b1;
          end else begin
            pin_nxt[idx_r] = 1'b0;
            dirty_nxt[idx_r] = 1'b1;
          end
        end else if (idx_r == LAST_IDX) begin
          if (op_r == OP_ACQUIRE) begin
            if (miss_r != '1) miss_nxt = miss_r + 32'd1;
            state_nxt = S_CHECK;
          end else begin
            ov_nxt = 1'b1; state_nxt = S_WAIT;
            res_nxt = '{KIND_STATUS, STAT_ABSENT, 1'b0, 4'd0, row_r, col_r, 4'd0, 1'b1};
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_CHECK: begin
        if (({1'b0, words_r} + 26'(size_r)) > 26'(cap_r) || nval_r == CW'(ENTRIES)) begin
          idx_nxt = '0; vf_nxt = 1'b0; state_nxt = S_VSCAN;
        end else begin
          state_nxt = S_INSTALL;
        end
      end
      S_VSCAN: begin
        if (take) begin
          vf_nxt = 1'b1; vs_nxt = idx_r; va_nxt = age_r[idx_r];
          vd_nxt = dirty_r[idx_r]; vrow_nxt = erow_r[idx_r]; vcol_nxt = ecol_r[idx_r];
          vsize_nxt = esize_r[idx_r]; vred_nxt = ered_r[idx_r];
        end
        if (idx_r == LAST_IDX) begin
          if (vf_r || take) begin
            state_nxt = S_EVICT;
          end else begin
            ov_nxt = 1'b1; state_nxt = S_WAIT;
            res_nxt = '{KIND_STATUS, STAT_PINNED, 1'b0, 4'd0, row_r, col_r, 4'd0, 1'b1};
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_EVICT: begin
        valid_nxt[vs_r] = 1'b0;
        dirty_nxt[vs_r] = 1'b0;
        words_nxt = words_r - 25'(vsize_r);
        nval_nxt = nval_r - 1'b1;
        for (int j = 0; j < ENTRIES; j++) begin
          if (valid_r[j] && age_r[j] > va_r) age_nxt[j] = age_r[j] - 1'b1;
        end
        if (vd_r) begin
          ov_nxt = 1'b1; state_nxt = S_WAIT; ret_nxt = S_CHECK;
          res_nxt = '{KIND_WB, STAT_OK, 1'b0, 4'(vs_r), vrow_r, vcol_r, vred_r, 1'b0};
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_INSTALL: begin
        wr_en = 1'b1;
        for (int j = 0; j < ENTRIES; j++) begin
          if (valid_r[j]) age_nxt[j] = age_r[j] + 1'b1;
        end
        age_nxt[free_slot] = '0;
        valid_nxt[free_slot] = 1'b1;
        pin_nxt[free_slot] = 1'b1;
        dirty_nxt[free_slot] = !bv_r;
        words_nxt = words_r + 25'(size_r);
        nval_nxt = nval_r + 1'b1;
        ov_nxt = 1'b1; state_nxt = S_WAIT;
        res_nxt = '{KIND_STATUS, STAT_OK, 1'b0, 4'(free_slot), row_r, col_r, red_r, 1'b1};
      end
      S_FLUSH: begin
        if (valid_r[idx_r] && dirty_r[idx_r]) begin
          dirty_nxt[idx_r] = 1'b0;
          ov_nxt = 1'b1; state_nxt = S_WAIT;
          ret_nxt = (idx_r == LAST_IDX) ? S_FLUSH_END : S_FLUSH;
          res_nxt = '{KIND_WB, STAT_OK, 1'b0, 4'(idx_r), erow_r[idx_r], ecol_r[idx_r],
                      ered_r[idx_r], 1'b0};
        end else if (idx_r == LAST_IDX) begin
          state_nxt = S_FLUSH_END;
        end
        if (idx_r != LAST_IDX) idx_nxt = idx_r + 1'b1;
      end
      S_FLUSH_END: begin
        ov_nxt = 1'b1; state_nxt = S_WAIT;
        res_nxt = '{KIND_STATUS, STAT_OK, 1'b0, 4'd0, 16'd0, 16'd0, 4'd0, 1'b1};
      end
      S_CLEAR: begin
        valid_nxt = '0; dirty_nxt = '0; pin_nxt = '0;
        for (int j = 0; j < ENTRIES; j++) age_nxt[j] = '0;
        words_nxt = '0; hits_nxt = '0; miss_nxt = '0; nval_nxt = '0;
        ov_nxt = 1'b1; state_nxt = S_WAIT;
        res_nxt = '{KIND_STATUS, STAT_OK, 1'b0, 4'd0, 16'd0, 16'd0, 4'd0, 1'b1};
      end
      S_WAIT: begin
        if (!out_stall) begin
          ov_nxt = 1'b0;
          state_nxt = res_r.last ? S_IDLE : ret_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      cap_r   <= 24'd1048576;
      valid_r <= '0;
      dirty_r <= '0;
      pin_r   <= '0;
      for (int j = 0; j < ENTRIES; j++) age_r[j] <= '0;
      words_r <= '0;
      hits_r  <= '0;
      miss_r  <= '0;
      nval_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      if (cfg_valid && cfg_ready) cap_r <= cfg_data;
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      pin_r   <= pin_nxt;
      for (int j = 0; j < ENTRIES; j++) age_r[j] <= age_nxt[j];
      words_r <= words_nxt;
      hits_r  <= hits_nxt;
      miss_r  <= miss_nxt;
      nval_r  <= nval_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    op_r <= op_nxt; row_r <= row_nxt; col_r <= col_nxt;
    size_r <= size_nxt; bv_r <= bv_nxt; red_r <= red_nxt;
    vf_r <= vf_nxt; vd_r <= vd_nxt; vs_r <= vs_nxt; va_r <= va_nxt;
    vrow_r <= vrow_nxt; vcol_r <= vcol_nxt; vsize_r <= vsize_nxt; vred_r <= vred_nxt;
    res_r <= res_nxt;
    if (wr_en) begin
      erow_r[wr_slot]  <= row_r;
      ecol_r[wr_slot]  <= col_r;
      esize_r[wr_slot] <= size_r;
      ered_r[wr_slot]  <= red_r;
    end
  end

endmodule

### rtl/plru_checker.sv
// ----------------------------------------------------------------------------
// plru_checker
// Port-level checks of the tile cache policy, bound to the top level.
// ----------------------------------------------------------------------------
module plru_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_kind,
  input logic [1:0] out_status,
  input logic       out_hit,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_last))
    else $error("stalled result changed");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == out_last))
    else $error("last flag does not match result kind");

  a_wb_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> out_status == 2'd0 && !out_hit)
    else $error("writeback carries status or hit");

endmodule

bind pinned_lru_tile_cache_policy_top plru_checker u_plru_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
  .out_status(out_status), .out_hit(out_hit), .out_last(out_last)
);

### bench/pinned_lru_tile_cache_policy_top_tb.sv
// ----------------------------------------------------------------------------
// pinned_lru_tile_cache_policy_top_tb
// Drives acquire, release, flush and clear operations into the tile cache
// policy. A behavioral directory model predicts each writeback and status
// result. Results are checked in order with random gaps on both channels, and
// the budget register is changed between phases.
// ----------------------------------------------------------------------------
module pinned_lru_tile_cache_policy_top_tb;
  import plru_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        kind;
    logic [1:0]  status;
    logic        hit;
    logic [3:0]  slot;
    logic [15:0] row;
    logic [15:0] col;
    logic [3:0]  red;
    logic [4:0]  resident;
    logic [31:0] hits;
    logic [31:0] misses;
    logic        last;
  } tile_res_t;

  class tile_directory;
    bit [23:0] budget;
    bit        valid [ENTRIES];
    bit [15:0] row [ENTRIES];
    bit [15:0] col [ENTRIES];
    bit [20:0] size [ENTRIES];
    bit        dirty [ENTRIES];
    bit        pinned [ENTRIES];
    bit [3:0]  red [ENTRIES];
    int        age [ENTRIES];
    longint    words;
    bit [31:0] hits, misses;
    tile_res_t pending[$];
    int        errors;

    function new();
      budget = 24'd1048576;
      wipe();
      errors = 0;
    endfunction

    function void wipe();
      foreach (valid[i]) begin
        valid[i] = 0; dirty[i] = 0; pinned[i] = 0; age[i] = 0;
        row[i] = 0; col[i] = 0; size[i] = 0; red[i] = 0;
      end
      words = 0; hits = 0; misses = 0;
    endfunction

    function int resident();
      int n;
      n = 0;
      foreach (valid[i]) n += valid[i];
      return n;
    endfunction

    function int lookup(bit [15:0] r, bit [15:0] c);
      foreach (valid[i]) if (valid[i] && row[i] == r && col[i] == c) return i;
      return -1;
    endfunction

    function void push(logic k, logic [1:0] st, logic h, int s, logic [15:0] r,
                       logic [15:0] c, logic [3:0] rd, logic l);
      tile_res_t e;
      e.kind = k; e.status = st; e.hit = h; e.slot = s[3:0]; e.row = r;
      e.col = c; e.red = rd; e.resident = 5'(resident()); e.hits = hits;
      e.misses = misses; e.last = l;
      pending.push_back(e);
    endfunction

    function void touch(int s, int old);
      foreach (valid[i]) if (valid[i] && i != s && age[i] < old) age[i]++;
      age[s] = 0;
    endfunction

    function void note_op(op_t op, bit [15:0] r, bit [15:0] c, bit [20:0] sz,
                          bit bv, bit [3:0] rk);
      int s, v, a;
      case (op)
        OP_ACQUIRE: begin
          s = lookup(r, c);
          if (s >= 0) begin
            if (hits != 32'hFFFF_FFFF) hits++;
            touch(s, age[s]);
            pinned[s] = 1;
            push(KIND_STATUS, STAT_OK, 1, s, r, c, red[s], 1);
            return;
          end
          if (misses != 32'hFFFF_FFFF) misses++;
          while (words + sz > budget || resident() >= ENTRIES) begin
            v = -1;
            foreach (valid[i])
              if (valid[i] && !pinned[i] && (v < 0 || age[i] > age[v])) v = i;
            if (v < 0) begin
              push(KIND_STATUS, STAT_PINNED, 0, 0, r, c, 0, 1);
              return;
            end
            a = age[v];
            valid[v] = 0;
            words -= size[v];
            foreach (valid[i]) if (valid[i] && age[i] > a) age[i]--;
            if (dirty[v]) begin
              dirty[v] = 0;
              push(KIND_WB, STAT_OK, 0, v, row[v], col[v], red[v], 0);
            end
          end
          s = 0;
          for (int i = 0; i < ENTRIES; i++) if (!valid[i]) begin s = i; break; end
          valid[s] = 1; row[s] = r; col[s] = c; size[s] = sz; red[s] = rk;
          pinned[s] = 1; dirty[s] = !bv;
          words += sz;
          touch(s, ENTRIES);
          push(KIND_STATUS, STAT_OK, 0, s, r, c, rk, 1);
        end
        OP_RELEASE: begin
          s = lookup(r, c);
          if (s < 0) begin
            push(KIND_STATUS, STAT_ABSENT, 0, 0, r, c, 0, 1);
          end else begin
            pinned[s] = 0; dirty[s] = 1;
            push(KIND_STATUS, STAT_OK, 0, s, r, c, red[s], 1);
          end
        end
        OP_FLUSH: begin
          foreach (valid[i])
            if (valid[i] && dirty[i]) begin
              dirty[i] = 0;
              push(KIND_WB, STAT_OK, 0, i, row[i], col[i], red[i], 0);
            end
          push(KIND_STATUS, STAT_OK, 0, 0, 0, 0, 0, 1);
        end
        default: begin
          wipe();
          push(KIND_STATUS, STAT_OK, 0, 0, 0, 0, 0, 1);
        end
      endcase
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(tile_res_t got);
      tile_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transfer, kind %0d", got.kind);
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("kind", e.kind, got.kind);
      cmp("status", e.status, got.status);
      cmp("hit", e.hit, got.hit);
      cmp("slot", e.slot, got.slot);
      cmp("row", e.row, got.row);
      cmp("col", e.col, got.col);
      cmp("reduction", e.red, got.red);
      cmp("resident_tiles", e.resident, got.resident);
      cmp("hit_total", e.hits, got.hits);
      cmp("miss_total", e.misses, got.misses);
      cmp("last", e.last, got.last);
    endfunction
  endclass

  logic        clk, rst_n;
  logic        cfg_valid, cfg_ready;
  logic [23:0] cfg_data;
  logic        in_valid, in_stall;
  logic [1:0]  in_operation;
  logic [15:0] in_tile_row, in_tile_col;
  logic [20:0] in_tile_size;
  logic        in_backing_valid;
  logic [3:0]  in_reduction_kind;
  logic        out_valid, out_stall;
  logic        out_kind, out_hit, out_last;
  logic [1:0]  out_status;
  logic [3:0]  out_slot, out_reduction;
  logic [15:0] out_row, out_col;
  logic [4:0]  out_resident_tiles;
  logic [31:0] out_hit_total, out_miss_total;

  pinned_lru_tile_cache_policy_top u_dut (.*);

  tile_directory dir = new();
  int ops_sent, results_seen, idle_cycles;
  bit drive_done;
  localparam int WATCHDOG = 20000;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_op(op_t op, bit [15:0] r, bit [15:0] c, bit [20:0] sz,
                         bit bv, bit [3:0] rk);
    int g;
    g = gap_len();
    repeat (g + 1) @(posedge clk);
    in_valid <= 1; in_operation <= op; in_tile_row <= r; in_tile_col <= c;
    in_tile_size <= sz; in_backing_valid <= bv; in_reduction_kind <= rk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    dir.note_op(op, r, c, sz, bv, rk);
    ops_sent++;
    in_valid <= 0;
  endtask

  task automatic drain_then_write(bit [23:0] val);
    while (dir.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    dir.budget = val;
  endtask

  task automatic random_op(int keyspace, bit [20:0] maxsz);
    int p;
    op_t op;
    p = $urandom_range(0, 99);
    if (p < 55) op = OP_ACQUIRE;
    else if (p < 88) op = OP_RELEASE;
    else if (p < 97) op = OP_FLUSH;
    else op = OP_CLEAR;
    if ($urandom_range(0, 9) == 0)
      send_op(op, 16'($urandom), 16'($urandom), 21'($urandom_range(0, 21'h1FFFFF)),
              1'($urandom), 4'($urandom));
    else
      send_op(op, 16'($urandom_range(0, keyspace)), 16'($urandom_range(0, 3)),
              21'($urandom_range(1, maxsz)), 1'($urandom), 4'($urandom));
  endtask

  // result side: random stalls, compare on each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        dir.check_result('{out_kind, out_status, out_hit, out_slot, out_row,
                           out_col, out_reduction, out_resident_tiles,
                           out_hit_total, out_miss_total, out_last});
        results_seen++;
      end
      out_stall <= (($urandom_range(0, 3) == 0) && !drive_done) ? 1'b1 :
                   ($urandom_range(0, 19) == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("pinned_lru_tile_cache_policy_top test failed");
      $finish;
    end
  end

  initial begin
    rst_n = 0; cfg_valid = 0; cfg_data = 0; in_valid = 0; in_operation = OP_ACQUIRE;
    in_tile_row = 0; in_tile_col = 0; in_tile_size = 0; in_backing_valid = 0;
    in_reduction_kind = 0;
    ops_sent = 0; results_seen = 0; drive_done = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, hits, misses, absent release, pinned-out, flush, clear
    send_op(OP_ACQUIRE, 16'hFFFF, 16'hFFFF, 21'd1, 0, 4'hF);
    send_op(OP_ACQUIRE, 16'h0000, 16'h0000, 21'h1FFFFF, 1, 4'h0);
    send_op(OP_ACQUIRE, 16'hFFFF, 16'hFFFF, 21'd5, 1, 4'h3);
    send_op(OP_RELEASE, 16'h1234, 16'h5678, 21'd1, 0, 4'h0);
    send_op(OP_RELEASE, 16'hFFFF, 16'hFFFF, 21'd1, 0, 4'h0);
    send_op(OP_ACQUIRE, 16'hAAAA, 16'h5555, 21'd0, 0, 4'hA);
    send_op(OP_ACQUIRE, 16'h5555, 16'hAAAA, 21'h100000, 0, 4'h5);
    send_op(OP_FLUSH, 0, 0, 0, 0, 0);
    send_op(OP_RELEASE, 16'hAAAA, 16'h5555, 21'd0, 0, 4'h0);
    send_op(OP_ACQUIRE, 16'h0001, 16'h0001, 21'h0FFFFF, 0, 4'h1);
    send_op(OP_CLEAR, 0, 0, 0, 0, 0);
    drain_then_write(24'd100);
    for (int i = 0; i < 17; i++)
      send_op(OP_ACQUIRE, 16'(i), 16'd7, 21'd1, i[0], i[3:0]);
    for (int i = 0; i < 8; i++) send_op(OP_RELEASE, 16'(i), 16'd7, 21'd1, 0, 0);
    send_op(OP_ACQUIRE, 16'd99, 16'd1, 21'd90, 0, 4'h9);

    // random phases over several budgets, extremes included
    drain_then_write(24'd0);
    repeat (12) random_op(6, 21'd4);
    drain_then_write(24'hFFFFFF);
    repeat (40) random_op(24, 21'd64);
    drain_then_write(24'd40);
    repeat (45) random_op(20, 21'd12);
    drain_then_write(24'd1000);
    repeat (36) random_op(30, 21'd200);
    @(posedge clk);
    drive_done = 1;

    while (dir.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Ran %0d operations, %0d result transfers checked, budgets 0 to max.",
             ops_sent, results_seen);
    if (dir.errors == 0 && dir.pending.size() == 0)
      $display("pinned_lru_tile_cache_policy_top test passed");
    else
      $display("pinned_lru_tile_cache_policy_top test failed");
    $finish;
  end
endmodule
